// File: src/particle_motion_wall_bounce_defines.svh
// ----------------------------------------------------------------------------
// particle_motion_wall_bounce_defines.svh
// Assertion macros for the particle motion block.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_MOTION_WALL_BOUNCE_DEFINES_SVH
`define PARTICLE_MOTION_WALL_BOUNCE_DEFINES_SVH

// Check that a condition implies another one in the same cycle.
`define PMWB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another one in the next cycle.
`define PMWB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pmwb_pkg.sv
// ----------------------------------------------------------------------------
// pmwb_pkg
// Shared constants, types and functions of the particle motion block.
// ----------------------------------------------------------------------------
package pmwb_pkg;

    localparam int FRAC_BITS     = 8;
    localparam int GRAVITY_FORCE = 10;
    localparam int ACC_NUM       = GRAVITY_FORCE << FRAC_BITS;
    localparam int ACC_W         = $clog2(ACC_NUM + 1);

    localparam int DIV_W      = 48;
    localparam int DIVR_W     = 16;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = DIV_W / DIV_BITS;

    localparam int ADDR_W = 5;
    localparam logic [ADDR_W-1:0] ADDR_TIME_SCALE  = 5'd0;
    localparam logic [ADDR_W-1:0] ADDR_GRAVITY_ON  = 5'd4;
    localparam logic [ADDR_W-1:0] ADDR_BOX_X_WIDTH = 5'd8;
    localparam logic [ADDR_W-1:0] ADDR_BOX_Y_WIDTH = 5'd12;
    localparam logic [ADDR_W-1:0] ADDR_WALL_MARGIN = 5'd16;

    typedef struct packed {
        logic [31:0] last_time;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic        mass_zero;
    } rec_t;

    typedef struct packed {
        logic [31:0]      now;
        logic [31:0]      dt;
        logic [ACC_W-1:0] acc;
        logic             mass_zero;
        logic [31:0]      px;
        logic [31:0]      py;
        logic [31:0]      pz;
        logic [31:0]      vx;
        logic [31:0]      vy;
        logic [31:0]      vz;
        logic [31:0]      ta;
        logic [31:0]      tb;
        logic [31:0]      tc;
        logic [31:0]      half;
        logic [32:0]      dd;
    } st_t;

    typedef struct packed {
        logic        flip;
        logic [31:0] pos;
    } refl_t;

    function automatic refl_t reflect_axis(logic [31:0] p, logic [15:0] width,
                                           logic [14:0] margin);
        logic signed [33:0] ps;
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        logic signed [33:0] sum;
        refl_t              r;
        ps  = 34'(signed'(p));
        hi  = 34'(signed'({2'b00, width})) - 34'(signed'({3'b000, margin}));
        hi  = hi <<< FRAC_BITS;
        lo  = 34'(signed'({3'b000, margin})) <<< FRAC_BITS;
        r.flip = 1'b1;
        if (ps >= hi) begin
            sum = (hi <<< 1) - ps;
        end else if (ps <= lo) begin
            sum = (lo <<< 1) - ps;
        end else begin
            sum    = ps;
            r.flip = 1'b0;
        end
        r.pos = sum[31:0];
        return r;
    endfunction

endpackage

// File: src/pmwb_div.sv
// ----------------------------------------------------------------------------
// pmwb_div
// Pipelined restoring divider, DIV_BITS (4) quotient bits per stage.
// ----------------------------------------------------------------------------
module pmwb_div import pmwb_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DIVR_W-1:0] divisor,
    output logic [DIV_W-1:0]  quotient
);

    logic [DIV_W-1:0]  w_reg [DIV_STAGES];
    logic [DIVR_W-1:0] r_reg [DIV_STAGES];
    logic [DIVR_W-1:0] d_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_st
        logic [DIV_W-1:0]  w_src;
        logic [DIVR_W-1:0] r_src;
        logic [DIVR_W-1:0] d_src;
        logic [DIV_W-1:0]  w_next;
        logic [DIVR_W-1:0] r_next;

        if (s == 0) begin : g_first
            assign w_src = dividend;
            assign r_src = '0;
            assign d_src = divisor;
        end else begin : g_rest
            assign w_src = w_reg[s-1];
            assign r_src = r_reg[s-1];
            assign d_src = d_reg[s-1];
        end

        always_comb
        begin
            logic [DIVR_W:0] t;
            w_next = w_src;
            r_next = r_src;
            for (int j = 0; j < DIV_BITS; j++)
            begin
                t = {r_next, w_next[DIV_W-1]};
                if (t >= {1'b0, d_src})
                begin
                    r_next = DIVR_W'(t - {1'b0, d_src});
                    w_next = {w_next[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    r_next = t[DIVR_W-1:0];
                    w_next = {w_next[DIV_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                w_reg[s] <= w_next;
                r_reg[s] <= r_next;
                d_reg[s] <= d_src;
            end
        end
    end

    assign quotient = w_reg[DIV_STAGES-1];

endmodule

// File: src/particle_motion_wall_bounce.sv
// ----------------------------------------------------------------------------
// particle_motion_wall_bounce
// Kinematic step of one particle per transfer with wall reflection on x and y.
//
//   channel | signals                               | direction
//   in      | in_valid, in_ready, tick .. last_time | into block
//   out     | out_valid, out_ready, new_pos_x ..    | out of block
//   cfg     | psel, penable, pwrite, paddr, pwdata  | APB write/read
//
// One transfer per cycle while out does not stall; the pipeline depth is set by
// the 48-bit tick divider (4 quotient bits per stage) and the multiply stages.
// Reset clears the valid bits and loads the register defaults.
// A stall on out freezes the whole pipeline; in_ready follows it.
// ----------------------------------------------------------------------------
`include "particle_motion_wall_bounce_defines.svh"

module particle_motion_wall_bounce import pmwb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [47:0]       tick,
    input  logic [31:0]       pos_x,
    input  logic [31:0]       pos_y,
    input  logic [31:0]       pos_z,
    input  logic [31:0]       vel_x,
    input  logic [31:0]       vel_y,
    input  logic [31:0]       vel_z,
    input  logic [15:0]       mass,
    input  logic [31:0]       last_time,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       new_pos_x,
    output logic [31:0]       new_pos_y,
    output logic [31:0]       new_pos_z,
    output logic [31:0]       new_vel_x,
    output logic [31:0]       new_vel_y,
    output logic [31:0]       new_vel_z,
    output logic [31:0]       accel_y,
    output logic [31:0]       new_time,
    output logic              mass_zero
);

    localparam int NSTAGE = DIV_STAGES + 6;

    logic [15:0] time_scale_reg;
    logic        gravity_on_reg;
    logic [15:0] box_x_width_reg;
    logic [15:0] box_y_width_reg;
    logic [14:0] wall_margin_reg;

    logic              en;
    logic [NSTAGE-1:0] vld_reg;
    rec_t              rec_reg [DIV_STAGES];
    logic [DIV_W-1:0]  quot_time;
    logic [DIV_W-1:0]  quot_a;
    logic [15:0]       ts;
    st_t               s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg;
    st_t               s1_next, s2_next, s3_next, s4_next, s5_next, s6_next;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_scale_reg  <= 16'd1;
            gravity_on_reg  <= 1'b0;
            box_x_width_reg <= 16'd640;
            box_y_width_reg <= 16'd480;
            wall_margin_reg <= 15'd0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr)
                ADDR_TIME_SCALE:  time_scale_reg  <= pwdata[15:0];
                ADDR_GRAVITY_ON:  gravity_on_reg  <= pwdata[0];
                ADDR_BOX_X_WIDTH: box_x_width_reg <= pwdata[15:0];
                ADDR_BOX_Y_WIDTH: box_y_width_reg <= pwdata[15:0];
                ADDR_WALL_MARGIN: wall_margin_reg <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_TIME_SCALE:  prdata = {16'd0, time_scale_reg};
            ADDR_GRAVITY_ON:  prdata = {31'd0, gravity_on_reg};
            ADDR_BOX_X_WIDTH: prdata = {16'd0, box_x_width_reg};
            ADDR_BOX_Y_WIDTH: prdata = {16'd0, box_y_width_reg};
            ADDR_WALL_MARGIN: prdata = {17'd0, wall_margin_reg};
            default:          prdata = '0;
        endcase
    end

    // pipeline control
    assign en        = !vld_reg[NSTAGE-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTAGE-2:0], in_valid};
    end

    // dividers: scaled time and acceleration
    assign ts = (time_scale_reg == 16'd0) ? 16'd1 : time_scale_reg;

    pmwb_div u_div_time (
        .clk      (clk),
        .en       (en),
        .dividend (tick),
        .divisor  (ts),
        .quotient (quot_time)
    );

    pmwb_div u_div_acc (
        .clk      (clk),
        .en       (en),
        .dividend (DIV_W'(ACC_NUM)),
        .divisor  (mass),
        .quotient (quot_a)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rec_reg[0] <= '{last_time: last_time, pos_x: pos_x, pos_y: pos_y,
                            pos_z: pos_z, vel_x: vel_x, vel_y: vel_y,
                            vel_z: vel_z, mass_zero: (mass == 16'd0)};
            for (int i = 1; i < DIV_STAGES; i++)
                rec_reg[i] <= rec_reg[i-1];
        end
    end

    // time step and acceleration
    always_comb
    begin
        rec_t r;
        r               = rec_reg[DIV_STAGES-1];
        s1_next         = '0;
        s1_next.now     = quot_time[31:0];
        s1_next.dt      = quot_time[31:0] - r.last_time;
        s1_next.acc     = (gravity_on_reg && !r.mass_zero) ? quot_a[ACC_W-1:0] : '0;
        s1_next.mass_zero = r.mass_zero;
        s1_next.px      = r.pos_x;
        s1_next.py      = r.pos_y;
        s1_next.pz      = r.pos_z;
        s1_next.vx      = r.vel_x;
        s1_next.vy      = r.vel_y;
        s1_next.vz      = r.vel_z;
    end

    // products with dt
    always_comb
    begin
        logic [ACC_W+31:0] pa;
        logic [63:0]       pb;
        logic [63:0]       pc;
        logic [63:0]       pd;
        pa = {32'd0, s1_reg.acc} * {{ACC_W{1'b0}}, s1_reg.dt};
        pb = {32'd0, s1_reg.vx} * {32'd0, s1_reg.dt};
        pc = {32'd0, s1_reg.vz} * {32'd0, s1_reg.dt};
        pd = {32'd0, s1_reg.dt} * {32'd0, s1_reg.dt};
        s2_next    = s1_reg;
        s2_next.ta = pa[31:0];
        s2_next.tb = pb[31:0];
        s2_next.tc = pc[31:0];
        s2_next.dd = pd[32:0];
    end

    // velocity update, half term, x and z position
    always_comb
    begin
        logic [ACC_W+32:0] ph;
        ph = {33'd0, s2_reg.acc} * {{ACC_W{1'b0}}, s2_reg.dd};
        s3_next      = s2_reg;
        s3_next.vy   = s2_reg.vy + s2_reg.ta;
        s3_next.half = ph[32:1];
        s3_next.px   = s2_reg.px + s2_reg.tb;
        s3_next.pz   = s2_reg.pz + s2_reg.tc;
    end

    // y velocity times dt
    always_comb
    begin
        logic [63:0] pv;
        pv = {32'd0, s3_reg.vy} * {32'd0, s3_reg.dt};
        s4_next    = s3_reg;
        s4_next.ta = pv[31:0];
    end

    // y position
    always_comb
    begin
        s5_next    = s4_reg;
        s5_next.py = s4_reg.py + s4_reg.ta + s4_reg.half;
    end

    // wall reflection
    always_comb
    begin
        refl_t rx;
        refl_t ry;
        rx = reflect_axis(s5_reg.px, box_x_width_reg, wall_margin_reg);
        ry = reflect_axis(s5_reg.py, box_y_width_reg, wall_margin_reg);
        s6_next    = s5_reg;
        s6_next.px = rx.pos;
        s6_next.py = ry.pos;
        s6_next.vx = rx.flip ? 32'd0 - s5_reg.vx : s5_reg.vx;
        s6_next.vy = ry.flip ? 32'd0 - s5_reg.vy : s5_reg.vy;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
        end
    end

    assign new_pos_x = s6_reg.px;
    assign new_pos_y = s6_reg.py;
    assign new_pos_z = s6_reg.pz;
    assign new_vel_x = s6_reg.vx;
    assign new_vel_y = s6_reg.vy;
    assign new_vel_z = s6_reg.vz;
    assign accel_y   = {{(32-ACC_W){1'b0}}, s6_reg.acc};
    assign new_time  = s6_reg.now;
    assign mass_zero = s6_reg.mass_zero;

    `PMWB_ASSERT_SAME(a_mass_zero_acc, out_valid && mass_zero, accel_y == 32'd0,
        "zero mass with nonzero acceleration")
    `PMWB_ASSERT_NEXT(a_stall_freeze, !en, vld_reg == $past(vld_reg),
        "pipeline moved during stall")
    `PMWB_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld_reg[0],
        "accepted transfer not in first stage")

endmodule

// File: verif/tb_particle_motion_wall_bounce.sv
// ----------------------------------------------------------------------------
// tb_particle_motion_wall_bounce
// Checks the particle kinematic step against an independent predictor.
// Directed records hit the field extremes, zero mass, zero time scale and
// margins beyond the box, then random records stream through under random
// idling, one long output stall, and several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_particle_motion_wall_bounce;
    import pmwb_pkg::*;

    typedef struct {
        logic [47:0] tick;
        logic [31:0] px, py, pz, vx, vy, vz;
        logic [15:0] mass;
        logic [31:0] last;
    } particle_t;

    typedef struct {
        logic [31:0] px, py, pz, vx, vy, vz, acc, now;
        logic        mz;
    } motion_t;

    class motion_scoreboard;
        motion_t     pending[$];
        int          errors;
        logic [15:0] scale_r;
        logic        grav_r;
        logic [15:0] xw_r, yw_r;
        logic [14:0] margin_r;

        function new();
            errors   = 0;
            scale_r  = 16'd1;
            grav_r   = 1'b0;
            xw_r     = 16'd640;
            yw_r     = 16'd480;
            margin_r = 15'd0;
        endfunction

        function logic bounce(ref logic [31:0] p, input logic [15:0] w);
            longint hi, lo, ps;
            hi = (longint'(w) - longint'(margin_r)) * 256;
            lo = longint'(margin_r) * 256;
            ps = longint'($signed(p));
            if (ps >= hi) begin
                p = 32'(2 * hi - ps);
                return 1'b1;
            end
            if (ps <= lo) begin
                p = 32'(2 * lo - ps);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_particle(particle_t r);
            motion_t     m;
            logic [63:0] ts, dtw, prod;
            logic [31:0] dtu, half;
            ts    = (scale_r == 0) ? 64'd1 : 64'(scale_r);
            m.now = 32'(64'(r.tick) / ts);
            dtu   = m.now - r.last;
            dtw   = 64'(longint'($signed(dtu)));
            m.mz  = (r.mass == 0);
            m.acc = 0;
            if (grav_r && r.mass != 0)
                m.acc = 32'((64'(GRAVITY_FORCE) << FRAC_BITS) / 64'(r.mass));
            m.vx = r.vx;
            m.vz = r.vz;
            m.vy = r.vy + m.acc * dtu;
            prod = 64'(m.acc) * dtw * dtw;
            half = 32'((prod & 64'h1_FFFF_FFFF) >> 1);
            m.px = r.px + m.vx * dtu;
            m.py = r.py + m.vy * dtu + half;
            m.pz = r.pz + m.vz * dtu;
            if (bounce(m.px, xw_r))
                m.vx = 32'd0 - m.vx;
            if (bounce(m.py, yw_r))
                m.vy = 32'd0 - m.vy;
            pending.push_back(m);
        endfunction

        function void cmp(string n, logic [31:0] e, logic [31:0] a);
            if (e !== a) begin
                errors++;
                $display("%0t mismatch %s: expected %h actual %h", $time, n, e, a);
            end
        endfunction

        function void check_motion(motion_t a);
            motion_t e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none actual px=%h", $time, a.px);
                return;
            end
            e = pending.pop_front();
            cmp("new_pos_x", e.px, a.px);
            cmp("new_pos_y", e.py, a.py);
            cmp("new_pos_z", e.pz, a.pz);
            cmp("new_vel_x", e.vx, a.vx);
            cmp("new_vel_y", e.vy, a.vy);
            cmp("new_vel_z", e.vz, a.vz);
            cmp("accel_y", e.acc, a.acc);
            cmp("new_time", e.now, a.now);
            cmp("mass_zero", 32'(e.mz), 32'(a.mz));
        endfunction
    endclass

    logic clk = 0, rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    logic pready;
    logic in_valid = 0, in_ready;
    logic [47:0] tick = '0;
    logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0, vel_x = '0, vel_y = '0, vel_z = '0;
    logic [15:0] mass = '0;
    logic [31:0] last_time = '0;
    logic out_valid, out_ready = 0;
    logic [31:0] new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z;
    logic [31:0] accel_y, new_time;
    logic mass_zero;

    motion_scoreboard sb = new();
    bit quiet = 0;
    int hold_off = 0;

    always #5 clk = ~clk;

    particle_motion_wall_bounce dut (.*);

    always @(posedge clk) begin
        motion_t a;
        if (rst_n && out_valid && out_ready) begin
            a.px = new_pos_x; a.py = new_pos_y; a.pz = new_pos_z;
            a.vx = new_vel_x; a.vy = new_vel_y; a.vz = new_vel_z;
            a.acc = accel_y; a.now = new_time; a.mz = mass_zero;
            sb.check_motion(a);
        end
    end

    initial begin
        int idle;
        idle = 0;
        forever begin
            @(negedge clk);
            if (hold_off > 0) begin
                hold_off--;
                out_ready <= 0;
            end else if (idle > 0) begin
                idle--;
                out_ready <= 0;
            end else begin
                out_ready <= 1;
                if (!quiet && $urandom_range(0, 9) == 0)
                    idle = $urandom_range(1, 15);
            end
        end
    end

    task automatic write_reg(logic [ADDR_W-1:0] a, logic [31:0] d);
        @(negedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= d;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic set_config(logic [15:0] ts, logic g, logic [15:0] xw,
                              logic [15:0] yw, logic [14:0] m);
        write_reg(ADDR_TIME_SCALE, 32'(ts));
        write_reg(ADDR_GRAVITY_ON, 32'(g));
        write_reg(ADDR_BOX_X_WIDTH, 32'(xw));
        write_reg(ADDR_BOX_Y_WIDTH, 32'(yw));
        write_reg(ADDR_WALL_MARGIN, 32'(m));
        sb.scale_r = ts; sb.grav_r = g; sb.xw_r = xw; sb.yw_r = yw; sb.margin_r = m;
    endtask

    task automatic send(particle_t r);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        tick <= r.tick; pos_x <= r.px; pos_y <= r.py; pos_z <= r.pz;
        vel_x <= r.vx; vel_y <= r.vy; vel_z <= r.vz; mass <= r.mass; last_time <= r.last;
        in_valid <= 1;
        do @(posedge clk); while (!in_ready);
        sb.note_particle(r);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic logic [31:0] rnd_coord(logic [15:0] w);
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($urandom_range(0, 32'(w) * 256 + 512));
            2: return 32'($signed($urandom_range(0, 4096)) - 2048);
            default: return 32'($urandom_range(0, 32'(w) * 256));
        endcase
    endfunction

    function automatic particle_t rnd_particle();
        particle_t r;
        logic [31:0] now;
        r.tick = {$urandom(), $urandom()};
        if ($urandom_range(0, 3) == 0) r.tick = 48'($urandom_range(0, 100000));
        now = 32'(64'(r.tick) / ((sb.scale_r == 0) ? 64'd1 : 64'(sb.scale_r)));
        r.last = ($urandom_range(0, 3) == 0) ? $urandom() : now - $urandom_range(0, 40) + 8;
        r.px = rnd_coord(sb.xw_r); r.py = rnd_coord(sb.yw_r); r.pz = $urandom();
        r.vx = ($urandom_range(0, 2) == 0) ? $urandom() : 32'($signed($urandom_range(0, 8191)) - 4096);
        r.vy = ($urandom_range(0, 2) == 0) ? $urandom() : 32'($signed($urandom_range(0, 8191)) - 4096);
        r.vz = $urandom();
        case ($urandom_range(0, 5))
            0: r.mass = 0;
            1: r.mass = 16'hFFFF;
            2: r.mass = 16'($urandom_range(1, 20));
            default: r.mass = 16'($urandom());
        endcase
        return r;
    endfunction

    initial begin
        particle_t r;
        logic [31:0] ext[4];
        ext = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        foreach (ext[i]) begin
            r.tick = (i % 2) ? 48'hFFFF_FFFF_FFFF : 48'(i * 7);
            r.px = ext[i]; r.py = ext[3 - i]; r.pz = ext[i];
            r.vx = ext[3 - i]; r.vy = ext[i]; r.vz = ext[3 - i];
            r.mass = (i == 0) ? 16'd0 : (i == 1) ? 16'hFFFF : 16'd1;
            r.last = ext[(i + 1) % 4];
            send(r);
        end
        drain();
        set_config(16'd0, 1'b1, 16'hFFFF, 16'd0, 15'h7FFF);
        foreach (ext[i]) begin
            r = rnd_particle();
            r.px = ext[i]; r.py = ext[(i + 2) % 4];
            r.mass = (i == 0) ? 16'd0 : 16'(i);
            send(r);
        end
        drain();
        set_config(16'hFFFF, 1'b1, 16'd0, 16'hFFFF, 15'd0);
        repeat (6) send(rnd_particle());
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_config(16'd1, 1'b1, 16'd640, 16'd480, 15'd16);
                1: set_config(16'd3, 1'b0, 16'd100, 16'd50, 15'd200);
                2: set_config(16'($urandom()), 1'b1, 16'($urandom()), 16'($urandom()),
                              15'($urandom()));
                3: set_config(16'd1, 1'b1, 16'd20, 16'd20, 15'd2);
                4: set_config(16'd0, 1'b0, 16'hFFFF, 16'hFFFF, 15'h7FFF);
                default: set_config(16'd7, 1'b1, 16'd640, 16'd480, 15'd0);
            endcase
            if (ph == 1) hold_off = 200;
            if (ph == 5) quiet = 1;
            repeat (320) send(rnd_particle());
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

// File: sim.f
+incdir+src
src/pmwb_pkg.sv
src/pmwb_div.sv
src/particle_motion_wall_bounce.sv
verif/tb_particle_motion_wall_bounce.sv
